// File: src/fcd_pkg.sv
package fcd_pkg;

    // Frame limits and window geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SIZE_W      = 9;
    localparam int MIN_SIZE    = 7;
    localparam int WIN_N       = 7;
    localparam int LINES       = 6;
    localparam int EDGE        = 3;
    localparam int RING_POINTS = 16;
    localparam int FULL_NEEDED = 10;
    localparam int QUICK_NEEDED = 3;

    // Result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // Configuration register indexes
    localparam int CFG_ADDR_W  = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_THRESHOLD = 2'd2;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH    = 9'd160;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT   = 9'd120;
    localparam logic [7:0]        RST_DIFF_THRESHOLD = 8'd20;

    // Ring of 16 points, as (cell, row) into the 7x7 window
    localparam int RING_COL [RING_POINTS] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
    localparam int RING_ROW [RING_POINTS] = '{3, 2, 1, 0, 0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4};

    typedef logic [7:0] pix_t;
    typedef pix_t [WIN_N-1:0] col_t;    // index 0 = oldest row
    typedef pix_t [LINES-1:0] line_t;   // one line store column
    typedef col_t [WIN_N-1:0] win_t;    // index 0 = oldest column

    typedef struct packed {
        logic             elig;
        logic [7:0]       cx;
        logic [7:0]       cy;
    } tag_t;

    typedef struct packed {
        logic [7:0]       cy;
        logic [7:0]       cx;
    } result_t;

endpackage

// File: src/fcd_ram.sv
module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/fcd_win_cell.sv
// One window column; shifts toward the older neighbor on each item.
module fcd_win_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  fcd_pkg::col_t col_in,
    output fcd_pkg::col_t col_out
);

    fcd_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// File: src/fcd_ring_test.sv
// Per ring point: |p - centre| > threshold.
module fcd_ring_test (
    input  fcd_pkg::win_t                   win,
    input  logic [7:0]                      threshold,
    output logic [fcd_pkg::RING_POINTS-1:0] exceed
);

    fcd_pkg::pix_t centre;

    assign centre = win[fcd_pkg::EDGE][fcd_pkg::EDGE];

    for (genvar i = 0; i < fcd_pkg::RING_POINTS; i++) begin : g_pt
        fcd_pkg::pix_t p;
        fcd_pkg::pix_t d;
        assign p = win[fcd_pkg::RING_COL[i]][fcd_pkg::RING_ROW[i]];
        assign d = (p > centre) ? (p - centre) : (centre - p);
        assign exceed[i] = (d > threshold);
    end

endmodule

// File: src/fcd_out_fifo.sv
// Small result queue; head is shown combinationally.
module fcd_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  fcd_pkg::result_t          push_data,
    input  logic                      pop,
    output fcd_pkg::result_t          head,
    output logic                      not_empty,
    output logic [fcd_pkg::FIFO_AW:0] count
);

    fcd_pkg::result_t                mem_reg [fcd_pkg::FIFO_DEPTH];
    logic [fcd_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fcd_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fcd_pkg::FIFO_AW:0]       count_reg, count_next;
    logic                            do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// File: src/fast_corner_detect.sv
// Path: an accepted pixel that completes a corner goes through the line store read,
//   window shift and ring compare, each registered, then into the result queue (m_tvalid).
// Throughput: one pixel per cycle while s_tready is high, set by the line store's single
//   read and single write port, each used once per item; an 8-entry result queue absorbs stalls.
// Reset: aresetn is synchronous, active low; clears position, pipeline valids, the
//   result queue and the registers (width 160, height 120, threshold 20).
module fast_corner_detect (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] pixel
    input  logic                            s_tuser,    // [0] frame_start

    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,    // [7:0] corner_x, [15:8] corner_y

    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [fcd_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [fcd_pkg::SIZE_W-1:0]      cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fcd_pkg::SIZE_W-1:0] width_reg;
    logic [fcd_pkg::SIZE_W-1:0] height_reg;
    logic [7:0]                 thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= fcd_pkg::RST_FRAME_WIDTH;
            height_reg <= fcd_pkg::RST_FRAME_HEIGHT;
            thresh_reg <= fcd_pkg::RST_DIFF_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fcd_pkg::REG_FRAME_WIDTH:    width_reg  <= cfg_wdata;
                fcd_pkg::REG_FRAME_HEIGHT:   height_reg <= cfg_wdata;
                fcd_pkg::REG_DIFF_THRESHOLD: thresh_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Clamped frame size
    logic [fcd_pkg::SIZE_W-1:0] w_eff, h_eff;

    always_comb begin
        if (width_reg < fcd_pkg::SIZE_W'(fcd_pkg::MIN_SIZE)) begin
            w_eff = fcd_pkg::SIZE_W'(fcd_pkg::MIN_SIZE);
        end else if (width_reg > fcd_pkg::SIZE_W'(fcd_pkg::MAX_WIDTH)) begin
            w_eff = fcd_pkg::SIZE_W'(fcd_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < fcd_pkg::SIZE_W'(fcd_pkg::MIN_SIZE)) begin
            h_eff = fcd_pkg::SIZE_W'(fcd_pkg::MIN_SIZE);
        end else if (height_reg > fcd_pkg::SIZE_W'(fcd_pkg::MAX_HEIGHT)) begin
            h_eff = fcd_pkg::SIZE_W'(fcd_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, raster position, line store read
    // ------------------------------------------------------------------
    logic                        s_acc;
    logic [fcd_pkg::COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [fcd_pkg::ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [fcd_pkg::COL_W-1:0]   col0;
    logic [fcd_pkg::ROW_W-1:0]   row0;
    fcd_pkg::tag_t               tag0;

    assign s_acc = s_tvalid && s_tready;
    assign col0  = s_tuser ? '0 : col_pos_reg;
    assign row0  = s_tuser ? '0 : row_pos_reg;

    always_comb begin
        tag0.elig = (col0 >= fcd_pkg::COL_W'(fcd_pkg::LINES))
                 && (row0 >= fcd_pkg::ROW_W'(fcd_pkg::LINES))
                 && ({1'b0, col0} < w_eff)
                 && ({1'b0, row0} < h_eff);
        tag0.cx   = 8'(col0 - fcd_pkg::COL_W'(fcd_pkg::EDGE));
        tag0.cy   = 8'(row0 - fcd_pkg::ROW_W'(fcd_pkg::EDGE));

        // advance position; wraps at row and frame end
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (s_acc) begin
            if (({1'b0, col0} + 1'b1) < w_eff) begin
                col_pos_next = col0 + 1'b1;
                row_pos_next = row0;
            end else begin
                col_pos_next = '0;
                row_pos_next = (({1'b0, row0} + 1'b1) < h_eff) ? row0 + 1'b1 : '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: line store data comes back, window shifts
    // ------------------------------------------------------------------
    logic                        v1_reg;
    fcd_pkg::tag_t               tag1_reg;
    fcd_pkg::pix_t               px1_reg;
    logic [fcd_pkg::COL_W-1:0]   col1_reg;
    logic                        hit_reg;      // read collided with a same-column write
    fcd_pkg::line_t              hold_reg;     // data of that write
    fcd_pkg::line_t              ls_rdata;
    fcd_pkg::line_t              ls_old;
    fcd_pkg::col_t               new_col;
    fcd_pkg::line_t              ls_wdata;

    assign ls_old   = hit_reg ? hold_reg : ls_rdata;
    assign new_col  = {px1_reg, ls_old};           // oldest row at index 0
    assign ls_wdata = new_col[fcd_pkg::WIN_N-1:1]; // drop oldest, keep the rest

    fcd_ram #(
        .WIDTH ($bits(fcd_pkg::line_t)),
        .DEPTH (fcd_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (aclk),
        .we    (v1_reg),
        .waddr (col1_reg),
        .wdata (ls_wdata),
        .re    (s_acc),
        .raddr (col0),
        .rdata (ls_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            v1_reg      <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            v1_reg      <= s_acc;
            hit_reg     <= s_acc && v1_reg && (col1_reg == col0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tag1_reg <= tag0;
            px1_reg  <= s_tdata;
            col1_reg <= col0;
        end
        hold_reg <= ls_wdata;
    end

    // Window: a chain of seven column cells, newest column enters cell 6
    fcd_pkg::win_t win;

    for (genvar c = 0; c < fcd_pkg::WIN_N; c++) begin : g_cell
        fcd_pkg::col_t cin;
        if (c == fcd_pkg::WIN_N - 1) begin : g_head
            assign cin = new_col;
        end else begin : g_link
            assign cin = win[c+1];
        end
        fcd_win_cell u_cell (
            .aclk     (aclk),
            .shift_en (v1_reg),
            .col_in   (cin),
            .col_out  (win[c])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: ring compares on the shifted window
    // ------------------------------------------------------------------
    logic                                v2_reg;
    fcd_pkg::tag_t                       tag2_reg;
    logic [fcd_pkg::RING_POINTS-1:0]     exceed;

    fcd_ring_test u_ring (
        .win       (win),
        .threshold (thresh_reg),
        .exceed    (exceed)
    );

    // ------------------------------------------------------------------
    // Stage 3: quick test and full count, push into result queue
    // ------------------------------------------------------------------
    logic                                v3_reg;
    fcd_pkg::tag_t                       tag3_reg;
    logic [fcd_pkg::RING_POINTS-1:0]     flags3_reg;
    logic [2:0]                          quick_cnt;
    logic [4:0]                          full_cnt;
    logic                                is_corner;
    logic                                fifo_push;
    fcd_pkg::result_t                    push_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            tag2_reg <= tag1_reg;
        end
        if (v2_reg) begin
            tag3_reg   <= tag2_reg;
            flags3_reg <= exceed;
        end
    end

    assign quick_cnt = 3'(flags3_reg[0]) + 3'(flags3_reg[4])
                     + 3'(flags3_reg[8]) + 3'(flags3_reg[12]);
    assign full_cnt  = 5'($countones(flags3_reg));
    assign is_corner = (quick_cnt == 3'(fcd_pkg::QUICK_NEEDED))
                    && (full_cnt >= 5'(fcd_pkg::FULL_NEEDED));
    assign fifo_push = v3_reg && tag3_reg.elig && is_corner;
    assign push_data = '{cy: tag3_reg.cy, cx: tag3_reg.cx};

    // ------------------------------------------------------------------
    // Result queue; input is held off when in-flight items could overflow it
    // ------------------------------------------------------------------
    fcd_pkg::result_t                    head;
    logic [fcd_pkg::FIFO_AW:0]           fifo_count;
    logic [fcd_pkg::FIFO_AW+1:0]         committed;

    fcd_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_data),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    // no item is taken while reset is held
    assign committed = {1'b0, fifo_count} + (fcd_pkg::FIFO_AW+2)'(v1_reg)
                     + (fcd_pkg::FIFO_AW+2)'(v2_reg) + (fcd_pkg::FIFO_AW+2)'(v3_reg);
    assign s_tready  = aresetn && (committed < (fcd_pkg::FIFO_AW+2)'(fcd_pkg::FIFO_DEPTH));
    assign m_tdata   = head;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (fifo_count < (fcd_pkg::FIFO_AW+1)'(fcd_pkg::FIFO_DEPTH))
                      || m_tready)
        else $error("result queue overflow");

    a_stage1_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> v1_reg)
        else $error("accepted item lost before stage 1");

    a_stage3_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> ##1 v3_reg)
        else $error("item lost between stages");

    a_hit_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg |-> v1_reg && $past(v1_reg))
        else $error("line store bypass without back-to-back items");

endmodule
